FILE: design/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// types, codes and the crc byte update shared by the frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESTINATION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BROADCAST   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXP_SOURCE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH  = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [8:0] MIN_FRAME_LEN = 9'd8;
    localparam logic [8:0] LEN_OVERHEAD  = 9'd4;
    localparam logic [8:0] APDU_OVERHEAD = 9'd8;

    localparam logic [8:0] POS_START  = 9'd0;
    localparam logic [8:0] POS_LENGTH = 9'd1;
    localparam logic [8:0] POS_DEST   = 9'd2;
    localparam logic [8:0] POS_SOURCE = 9'd3;
    localparam logic [8:0] POS_CLASS  = 9'd4;
    localparam logic [8:0] POS_OP     = 9'd5;
    localparam logic [8:0] POS_APDU   = 9'd6;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd2;

    typedef enum logic [3:0] {
        ST_INCOMPLETE = 4'd0,
        ST_OK         = 4'd1,
        ST_BAD_START  = 4'd2,
        ST_BAD_LENGTH = 4'd3,
        ST_BAD_ADDR   = 4'd4,
        ST_BAD_CRC    = 4'd5,
        ST_BAD_OP     = 4'd6,
        ST_BAD_APDU   = 4'd7,
        ST_OVERFLOW   = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        PH_RECEIVING = 2'd0,
        PH_CLOSED    = 2'd1
    } phase_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] destination;
        logic [7:0] broadcast;
        logic [7:0] exp_source;
        logic [8:0] max_length;
    } cfg_t;

    typedef struct packed {
        status_t    status;
        logic       frame_done;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [5:0] payload_index;
        logic [7:0] frame_class;
        logic [1:0] operation;
        logic [5:0] apdu_len;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] v;
        v = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (v[15])
            begin
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/rfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rfd_cfg_regs
// configuration register bank with plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rfd_pkg::cfg_t                        cfg
);
    import rfd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte  <= 8'd36;
            cfg_reg.destination <= 8'd1;
            cfg_reg.broadcast   <= 8'd255;
            cfg_reg.exp_source  <= 8'd255;
            cfg_reg.max_length  <= 9'd71;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE:  cfg_reg.start_byte  <= cfg_data[7:0];
                CFG_DESTINATION: cfg_reg.destination <= cfg_data[7:0];
                CFG_BROADCAST:   cfg_reg.broadcast   <= cfg_data[7:0];
                CFG_EXP_SOURCE:  cfg_reg.exp_source  <= cfg_data[7:0];
                CFG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/rfd_frame_core.sv
// ----------------------------------------------------------------------------
// rfd_frame_core
// frame state, crc accumulation and per-byte result logic
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_frame_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    input  wire logic       frame_restart,
    input  rfd_pkg::cfg_t   cfg,
    output rfd_pkg::result_t result
);
    import rfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [8:0]  frame_length_reg, frame_length_next;
    logic [15:0] crc_reg, crc_next;
    logic        address_ok_reg, address_ok_next;
    logic [7:0]  source_reg, source_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  op_byte_reg, op_byte_next;
    logic [7:0]  crc_high_reg, crc_high_next;

    phase_t      phase_eff;
    logic [8:0]  pos, flen, len_b, pos_apdu;
    logic [9:0]  pos_plus2;
    logic [15:0] crc_eff, crc_want;
    logic        addr_eff;
    logic [7:0]  src_eff, cls_eff, opb_eff, crch_eff;
    logic        long_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_RECEIVING;
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            crc_reg          <= CRC_INIT;
            address_ok_reg   <= 1'b0;
            source_reg       <= '0;
            class_reg        <= '0;
            op_byte_reg      <= '0;
            crc_high_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            frame_length_reg <= frame_length_next;
            crc_reg          <= crc_next;
            address_ok_reg   <= address_ok_next;
            source_reg       <= source_next;
            class_reg        <= class_next;
            op_byte_reg      <= op_byte_next;
            crc_high_reg     <= crc_high_next;
        end
    end

    always_comb
    begin
        phase_eff = frame_restart ? PH_RECEIVING : phase_reg;
        pos       = frame_restart ? 9'd0 : byte_count_reg;
        flen      = frame_restart ? 9'd0 : frame_length_reg;
        crc_eff   = frame_restart ? CRC_INIT : crc_reg;
        addr_eff  = frame_restart ? 1'b0 : address_ok_reg;
        src_eff   = frame_restart ? 8'd0 : source_reg;
        cls_eff   = frame_restart ? 8'd0 : class_reg;
        opb_eff   = frame_restart ? 8'd0 : op_byte_reg;
        crch_eff  = frame_restart ? 8'd0 : crc_high_reg;

        pos_plus2  = {1'b0, pos} + 10'd2;
        len_b      = {1'b0, rx_byte} + LEN_OVERHEAD;
        pos_apdu   = pos - POS_APDU;
        long_frame = (flen >= MIN_FRAME_LEN);
        crc_want   = ~crc_eff;

        phase_next        = phase_eff;
        byte_count_next   = pos;
        frame_length_next = flen;
        crc_next          = crc_eff;
        address_ok_next   = addr_eff;
        source_next       = src_eff;
        class_next        = cls_eff;
        op_byte_next      = opb_eff;
        crc_high_next     = crch_eff;

        result = '0;
        result.status = ST_INCOMPLETE;

        case (phase_eff)
            PH_RECEIVING:
            begin
                byte_count_next = pos + 9'd1;
                if (pos == POS_START)
                begin
                    if (rx_byte != cfg.start_byte)
                    begin
                        result.status     = ST_BAD_START;
                        result.frame_done = 1'b1;
                        phase_next        = PH_CLOSED;
                    end
                end
                else if (pos == POS_LENGTH)
                begin
                    if (len_b < MIN_FRAME_LEN || len_b > cfg.max_length)
                    begin
                        result.status     = ST_BAD_LENGTH;
                        result.frame_done = 1'b1;
                        phase_next        = PH_CLOSED;
                    end
                    else
                    begin
                        frame_length_next = len_b;
                        crc_next          = crc_byte(crc_eff, rx_byte);
                    end
                end
                else if (long_frame && pos_plus2 < {1'b0, flen})
                begin
                    crc_next = crc_byte(crc_eff, rx_byte);
                    if (pos == POS_DEST)
                    begin
                        address_ok_next = (rx_byte == cfg.destination);
                    end
                    else if (pos == POS_SOURCE)
                    begin
                        source_next = rx_byte;
                        if (rx_byte == cfg.broadcast)
                        begin
                            address_ok_next = 1'b0;
                        end
                    end
                    else if (pos == POS_CLASS)
                    begin
                        class_next = rx_byte;
                    end
                    else if (pos == POS_OP)
                    begin
                        op_byte_next = rx_byte;
                    end
                    else
                    begin
                        result.payload_valid = 1'b1;
                        result.payload_byte  = rx_byte;
                        result.payload_index = pos_apdu[5:0];
                    end
                end
                else if (long_frame && pos_plus2 == {1'b0, flen})
                begin
                    crc_high_next = rx_byte;
                end
                else
                begin
                    result.frame_done = 1'b1;
                    phase_next        = PH_CLOSED;
                    if (!addr_eff)
                    begin
                        result.status = ST_BAD_ADDR;
                    end
                    else if ({crch_eff, rx_byte} != crc_want)
                    begin
                        result.status = ST_BAD_CRC;
                    end
                    else if (src_eff != cfg.exp_source)
                    begin
                        result.status = ST_BAD_ADDR;
                    end
                    else if (opb_eff[7:6] != OP_GET && opb_eff[7:6] != OP_SET)
                    begin
                        result.status = ST_BAD_OP;
                    end
                    else if ({3'b000, opb_eff[5:0]} + APDU_OVERHEAD != flen)
                    begin
                        result.status = ST_BAD_APDU;
                    end
                    else
                    begin
                        result.status      = ST_OK;
                        result.frame_class = cls_eff;
                        result.operation   = opb_eff[7:6];
                        result.apdu_len    = opb_eff[5:0];
                    end
                end
            end
            default:
            begin
                result.status     = ST_OVERFLOW;
                result.frame_done = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/response_frame_deframer_crc.sv
// ----------------------------------------------------------------------------
// response_frame_deframer_crc
// length-prefixed response frame receiver with crc-16 check and apdu stream
// ----------------------------------------------------------------------------
//  channel  handshake              word
//  in       in_valid / in_ready    rx_byte, frame_restart
//  out      out_valid / out_ready  status, frame_done, payload_*, frame_class,
//                                  operation, apdu_len
//  cfg      cfg_we                 cfg_index, cfg_data
//
//  one byte per cycle sustained while results are taken; each byte passes the input register, then the result register
//  the byte crc update, frame compares and state update sit between the
//  input register and the result register
//  reset loads register defaults and clears frame state
//  a stalled result holds its register; the input register still takes one
//  more byte, then in_ready drops until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module response_frame_deframer_crc (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            frame_restart,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [3:0]                           status,
    output logic                                 frame_done,
    output logic                                 payload_valid,
    output logic [7:0]                           payload_byte,
    output logic [5:0]                           payload_index,
    output logic [7:0]                           frame_class,
    output logic [1:0]                           operation,
    output logic [5:0]                           apdu_len,
    input  wire logic                            cfg_we,
    input  wire logic [rfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rfd_pkg::*;

    cfg_t       cfg;
    result_t    result;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       restart_reg;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    rfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfd_frame_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .rx_byte       (byte_reg),
        .frame_restart (restart_reg),
        .cfg           (cfg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg    <= rx_byte;
            restart_reg <= frame_restart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign frame_done    = out_reg.frame_done;
    assign payload_valid = out_reg.payload_valid;
    assign payload_byte  = out_reg.payload_byte;
    assign payload_index = out_reg.payload_index;
    assign frame_class   = out_reg.frame_class;
    assign operation     = out_reg.operation;
    assign apdu_len      = out_reg.apdu_len;

`ifndef SYNTHESIS
    a_done_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_done == (status != ST_INCOMPLETE)))
        else $error("frame_done disagrees with status");

    a_payload_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(payload_valid && frame_done))
        else $error("apdu byte flagged on a final status");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    a_ok_operation: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (operation == OP_GET || operation == OP_SET))
        else $error("ok status with an invalid operation");
`endif

endmodule

`default_nettype wire

FILE: dv/response_frame_deframer_crc_test.sv
// ----------------------------------------------------------------------------
// response_frame_deframer_crc_test
// self-checking bench for the response frame receiver with crc-16 check
// ----------------------------------------------------------------------------
//  a short directed table runs first: wrong start byte, lengths out of range,
//  a bad address under the reset settings, an ok set frame with one apdu
//  byte, and bytes after a closed frame. random frames follow under several
//  register settings, including the length extremes and a limit below the
//  smallest frame. most random frames are well formed with random content;
//  the rest carry a bad crc, operation, apdu size, address, start or length,
//  are cut short, run long or are plain noise. every received word is checked
//  against its table entry or an in-bench model of the receiver, with random
//  gaps on both channels and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module response_frame_deframer_crc_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rfd_pkg::*;

    localparam int RANDOM_BYTES  = 600;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int REPORT_LIMIT  = 10;

    typedef enum logic [1:0] {
        SRC_TABLE,
        SRC_CRC_HI,
        SRC_CRC_LO
    } byte_src_t;

    typedef struct packed {
        logic       restart;
        logic [7:0] data;
        byte_src_t  src;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam result_t W_NONE       = '{status: ST_INCOMPLETE, default: '0};
    localparam result_t W_BAD_START  = '{status: ST_BAD_START, frame_done: 1'b1, default: '0};
    localparam result_t W_BAD_LENGTH = '{status: ST_BAD_LENGTH, frame_done: 1'b1, default: '0};
    localparam result_t W_BAD_ADDR   = '{status: ST_BAD_ADDR, frame_done: 1'b1, default: '0};
    localparam result_t W_OVERFLOW   = '{status: ST_OVERFLOW, frame_done: 1'b1, default: '0};
    localparam result_t W_APDU_80    = '{status: ST_INCOMPLETE, payload_valid: 1'b1,
                                         payload_byte: 8'h80, default: '0};
    localparam result_t W_OK_SET     = '{status: ST_OK, frame_done: 1'b1, frame_class: 8'hC3,
                                         operation: OP_SET, apdu_len: 6'd1, default: '0};

    localparam int DIR_ROWS         = 24;
    localparam int SECOND_SETUP_ROW = 14;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{1'b1, 8'h00, SRC_TABLE,  1'b1, W_BAD_START},
        '{1'b0, 8'hFF, SRC_TABLE,  1'b1, W_OVERFLOW},
        '{1'b1, 8'h24, SRC_TABLE,  1'b1, W_NONE},
        '{1'b0, 8'h00, SRC_TABLE,  1'b1, W_BAD_LENGTH},
        '{1'b1, 8'h24, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'hFF, SRC_TABLE,  1'b1, W_BAD_LENGTH},
        '{1'b1, 8'h24, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h04, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h01, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'hFF, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h5A, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h00, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h00, SRC_CRC_HI, 1'b0, W_NONE},
        '{1'b0, 8'h00, SRC_CRC_LO, 1'b1, W_BAD_ADDR},
        '{1'b1, 8'hA5, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h05, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h00, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'hFF, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'hC3, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h81, SRC_TABLE,  1'b0, W_NONE},
        '{1'b0, 8'h80, SRC_TABLE,  1'b1, W_APDU_80},
        '{1'b0, 8'h00, SRC_CRC_HI, 1'b0, W_NONE},
        '{1'b0, 8'h00, SRC_CRC_LO, 1'b1, W_OK_SET},
        '{1'b0, 8'h00, SRC_TABLE,  1'b1, W_OVERFLOW}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;
    logic                   frame_restart;
    logic                   out_valid;
    logic                   out_ready;
    logic [3:0]             status;
    logic                   frame_done;
    logic                   payload_valid;
    logic [7:0]             payload_byte;
    logic [5:0]             payload_index;
    logic [7:0]             frame_class;
    logic [1:0]             operation;
    logic [5:0]             apdu_len;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // receiver model state
    cfg_t        model_cfg;
    logic [8:0]  frame_pos;
    logic [8:0]  frame_len;
    logic [15:0] crc_run;
    logic        addr_good;
    logic [7:0]  src_byte;
    logic [7:0]  class_byte;
    logic [7:0]  op_byte;
    logic [7:0]  crc_hi_byte;
    phase_t      rx_phase;

    result_t pending_words [$];

    bit quiet_src;
    bit quiet_sink;
    bit hold_off_req;
    int bytes_sent;
    int frames_sent;
    int settings_used;
    int words_checked;
    int bad_words;
    int ok_frames;
    int rejected_frames;
    int overflow_words;
    int apdu_words;

    response_frame_deframer_crc u_top (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL response_frame_deframer_crc");
        $finish;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        frame_pos   = '0;
        frame_len   = '0;
        crc_run     = CRC_INIT;
        addr_good   = 1'b0;
        src_byte    = '0;
        class_byte  = '0;
        op_byte     = '0;
        crc_hi_byte = '0;
        rx_phase    = PH_RECEIVING;
    endfunction

    function automatic result_t deframe_byte(input logic [7:0] b, input logic restart);
        result_t w;
        int      pos;
        int      len;
        w = W_NONE;
        if (restart)
        begin
            clear_frame_state();
        end
        if (rx_phase != PH_RECEIVING)
        begin
            w.status     = ST_OVERFLOW;
            w.frame_done = 1'b1;
        end
        else
        begin
            pos       = frame_pos;
            frame_pos = frame_pos + 9'd1;
            if (pos == POS_START)
            begin
                if (b != model_cfg.start_byte)
                begin
                    w.status     = ST_BAD_START;
                    w.frame_done = 1'b1;
                    rx_phase     = PH_CLOSED;
                end
            end
            else if (pos == POS_LENGTH)
            begin
                len = int'(b) + int'(LEN_OVERHEAD);
                if (len < MIN_FRAME_LEN || len > model_cfg.max_length)
                begin
                    w.status     = ST_BAD_LENGTH;
                    w.frame_done = 1'b1;
                    rx_phase     = PH_CLOSED;
                end
                else
                begin
                    frame_len = 9'(len);
                    crc_run   = crc_step(crc_run, b);
                end
            end
            else if (frame_len >= MIN_FRAME_LEN && pos + 2 < frame_len)
            begin
                crc_run = crc_step(crc_run, b);
                if (pos == POS_DEST)
                begin
                    addr_good = (b == model_cfg.destination);
                end
                else if (pos == POS_SOURCE)
                begin
                    src_byte = b;
                    if (b == model_cfg.broadcast)
                    begin
                        addr_good = 1'b0;
                    end
                end
                else if (pos == POS_CLASS)
                begin
                    class_byte = b;
                end
                else if (pos == POS_OP)
                begin
                    op_byte = b;
                end
                else
                begin
                    w.payload_valid = 1'b1;
                    w.payload_byte  = b;
                    w.payload_index = 6'(pos - int'(POS_APDU));
                end
            end
            else if (frame_len >= MIN_FRAME_LEN && pos + 2 == frame_len)
            begin
                crc_hi_byte = b;
            end
            else
            begin
                w.frame_done = 1'b1;
                rx_phase     = PH_CLOSED;
                if (!addr_good)
                begin
                    w.status = ST_BAD_ADDR;
                end
                else if ({crc_hi_byte, b} != ~crc_run)
                begin
                    w.status = ST_BAD_CRC;
                end
                else if (src_byte != model_cfg.exp_source)
                begin
                    w.status = ST_BAD_ADDR;
                end
                else if (op_byte[7:6] != OP_GET && op_byte[7:6] != OP_SET)
                begin
                    w.status = ST_BAD_OP;
                end
                else if (int'(op_byte[5:0]) + int'(APDU_OVERHEAD) != frame_len)
                begin
                    w.status = ST_BAD_APDU;
                end
                else
                begin
                    w.status      = ST_OK;
                    w.frame_class = class_byte;
                    w.operation   = op_byte[7:6];
                    w.apdu_len    = op_byte[5:0];
                end
            end
        end
        return w;
    endfunction

    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 97)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 50);
    endfunction

    task automatic send_word(input logic [7:0] d, input logic restart, input bit typed,
                             input result_t want);
        result_t pred;
        int      gap;
        gap = hold_off_req ? 0 : idle_len(quiet_src);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        rx_byte       <= d;
        frame_restart <= restart;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pred = deframe_byte(d, restart);
        pending_words.push_back(typed ? want : pred);
        bytes_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_data  <= {1'b0, s.start_byte};
        @(posedge clk);
        cfg_index <= CFG_DESTINATION;
        cfg_data  <= {1'b0, s.destination};
        @(posedge clk);
        cfg_index <= CFG_BROADCAST;
        cfg_data  <= {1'b0, s.broadcast};
        @(posedge clk);
        cfg_index <= CFG_EXP_SOURCE;
        cfg_data  <= {1'b0, s.exp_source};
        @(posedge clk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= s.max_length;
        @(posedge clk);
        cfg_we    <= 1'b0;
        model_cfg = s;
        settings_used++;
    endtask

    task automatic send_frame(input bit longest);
        logic [7:0]  fq [$];
        logic [15:0] c;
        logic [1:0]  opc;
        logic        first_restart;
        int          kind;
        int          limit;
        int          n_apdu;
        int          cut;
        kind  = longest ? 0 : $urandom_range(0, 99);
        limit = (model_cfg.max_length >= MIN_FRAME_LEN) ?
                int'(model_cfg.max_length) - int'(APDU_OVERHEAD) : 0;
        if (limit > 251)
        begin
            limit = 251;
        end
        if (longest)
        begin
            n_apdu = limit;
        end
        else if ($urandom_range(0, 4) != 0)
        begin
            n_apdu = $urandom_range(0, 6);
        end
        else
        begin
            n_apdu = $urandom_range(0, 24);
        end
        if (n_apdu > limit)
        begin
            n_apdu = limit;
        end
        if (kind >= 94)
        begin
            // noise with random restarts
            repeat ($urandom_range(1, 6))
            begin
                send_word(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, W_NONE);
            end
            return;
        end
        opc = $urandom_range(0, 1) ? OP_SET : OP_GET;
        fq  = '{model_cfg.start_byte, 8'(n_apdu + 4), model_cfg.destination,
                model_cfg.exp_source, 8'($urandom), {opc, 6'(n_apdu)}};
        repeat (n_apdu) fq.push_back(8'($urandom));
        if (kind >= 60 && kind < 64)
        begin
            fq[5][7:6] = $urandom_range(0, 1) ? 2'd1 : 2'd3;
        end
        else if (kind >= 64 && kind < 68)
        begin
            fq[5][5:0] = 6'($urandom);
        end
        else if (kind >= 68 && kind < 72)
        begin
            fq[2] = 8'($urandom);
        end
        else if (kind >= 72 && kind < 75)
        begin
            fq[3] = model_cfg.broadcast;
        end
        else if (kind >= 75 && kind < 79)
        begin
            fq[3] = 8'($urandom);
        end
        c = CRC_INIT;
        for (int i = 1; i < fq.size(); i++)
        begin
            c = crc_step(c, fq[i]);
        end
        fq.push_back(~c[15:8]);
        fq.push_back(~c[7:0]);
        if (kind >= 55 && kind < 60)
        begin
            fq[fq.size() - 1] = fq[fq.size() - 1] ^ 8'(1 << $urandom_range(0, 7));
        end
        else if (kind >= 79 && kind < 82)
        begin
            fq[0] = fq[0] ^ 8'($urandom_range(1, 255));
        end
        else if (kind >= 82 && kind < 86)
        begin
            if (model_cfg.max_length > 258 || $urandom_range(0, 1) != 0)
            begin
                fq[1] = 8'($urandom_range(0, 3));
            end
            else
            begin
                fq[1] = 8'($urandom_range(int'(model_cfg.max_length) - 3, 255));
            end
            cut = $urandom_range(2, 4);
            while (fq.size() > cut)
            begin
                void'(fq.pop_back());
            end
        end
        else if (kind >= 86 && kind < 90)
        begin
            repeat ($urandom_range(1, 3)) fq.push_back(8'($urandom));
        end
        else if (kind >= 90)
        begin
            cut = $urandom_range(1, fq.size() - 1);
            while (fq.size() > cut)
            begin
                void'(fq.pop_back());
            end
        end
        first_restart = ($urandom_range(0, 19) != 0);
        foreach (fq[i])
        begin
            send_word(fq[i], (i == 0) ? first_restart : 1'b0, 1'b0, W_NONE);
        end
        frames_sent++;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                stall = idle_len(quiet_sink);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{status_t'(status), frame_done, payload_valid, payload_byte,
                    payload_index, frame_class, operation, apdu_len};
            if (pending_words.size() == 0)
            begin
                if (bad_words < REPORT_LIMIT)
                begin
                    $display("%0t: word with nothing pending, status %0d", $realtime, status);
                end
                bad_words++;
            end
            else
            begin
                want = pending_words.pop_front();
                words_checked++;
                if (want.status == ST_OK)
                begin
                    ok_frames++;
                end
                else if (want.status == ST_OVERFLOW)
                begin
                    overflow_words++;
                end
                else if (want.frame_done)
                begin
                    rejected_frames++;
                end
                if (want.payload_valid)
                begin
                    apdu_words++;
                end
                if (got.status !== want.status || got.frame_done !== want.frame_done ||
                    got.payload_valid !== want.payload_valid ||
                    got.payload_byte !== want.payload_byte ||
                    got.payload_index !== want.payload_index ||
                    got.frame_class !== want.frame_class ||
                    got.operation !== want.operation || got.apdu_len !== want.apdu_len)
                begin
                    if (bad_words < REPORT_LIMIT)
                    begin
                        $display({"%0t: mismatch exp/got status %0d/%0d done %b/%b ",
                                  "pv %b/%b byte %h/%h idx %0d/%0d class %h/%h ",
                                  "op %0d/%0d size %0d/%0d"}, $realtime,
                                 want.status, got.status, want.frame_done, got.frame_done,
                                 want.payload_valid, got.payload_valid,
                                 want.payload_byte, got.payload_byte,
                                 want.payload_index, got.payload_index,
                                 want.frame_class, got.frame_class,
                                 want.operation, got.operation,
                                 want.apdu_len, got.apdu_len);
                    end
                    bad_words++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t   row;
        logic [7:0] d;
        cfg_t       s;
        int         k;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        rx_byte       <= '0;
        frame_restart <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        model_cfg = '{start_byte: 8'd36, destination: 8'd1, broadcast: 8'd255,
                      exp_source: 8'd255, max_length: 9'd71};
        clear_frame_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == SECOND_SETUP_ROW)
            begin
                drain_results();
                apply_settings('{start_byte: 8'hA5, destination: 8'h00, broadcast: 8'h7E,
                                 exp_source: 8'hFF, max_length: 9'd259});
            end
            row = DIR_TABLE[i];
            case (row.src)
                SRC_CRC_HI: d = ~crc_run[15:8];
                SRC_CRC_LO: d = ~crc_run[7:0];
                default:    d = row.data;
            endcase
            send_word(d, row.restart, row.typed, row.want);
        end
        drain_results();

        k = 0;
        while (bytes_sent < DIR_ROWS + RANDOM_BYTES)
        begin
            s = '{start_byte: 8'($urandom), destination: 8'($urandom), broadcast: 8'h00,
                  exp_source: 8'($urandom), max_length: 9'($urandom_range(8, 259))};
            s.broadcast = s.exp_source ^ 8'($urandom_range(1, 255));
            case (k)
                0: s.max_length = 9'd259;
                1: s = '{start_byte: 8'hFF, destination: 8'hFF, broadcast: 8'h00,
                         exp_source: 8'hFF, max_length: 9'd8};
                // limit below the smallest frame: every length is refused
                2: s = '{start_byte: 8'h00, destination: 8'h00, broadcast: 8'hFF,
                         exp_source: 8'h00, max_length: 9'd5};
                3: s.max_length = 9'd71;
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        s.broadcast = s.exp_source;
                    end
                end
            endcase
            apply_settings(s);
            quiet_src  = ($urandom_range(0, 3) == 0);
            quiet_sink = ($urandom_range(0, 3) == 0);
            if (k == 0)
            begin
                hold_off_req = 1'b1;
            end
            for (int f = 0; f < ((k == 2) ? 4 : 14) && bytes_sent < DIR_ROWS + RANDOM_BYTES;
                 f++)
            begin
                send_frame(k == 0 && f == 1);
            end
            drain_results();
            k++;
        end

        $display("sent %0d words in %0d frames under %0d register settings",
                 bytes_sent, frames_sent, settings_used);
        $display("checked %0d words: %0d ok, %0d rejected, %0d overflow, %0d apdu bytes",
                 words_checked, ok_frames, rejected_frames, overflow_words, apdu_words);
        if (bad_words == 0)
        begin
            $display("PASS response_frame_deframer_crc");
        end
        else
        begin
            $display("FAIL response_frame_deframer_crc");
        end
        $finish;
    end

endmodule

`default_nettype wire
